// ===== src/sarnt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the suffix add / rightmost nonnegative tree search block.
// Holds tree sizes, the controller-to-datapath command and status types, and helpers.
package sarnt_pkg;

  localparam int KEY_W   = 10;
  localparam int ANS_W   = 11;
  localparam int NODE_W  = KEY_W + 1;
  localparam int VAL_W   = 32;
  localparam int LEVELS  = KEY_W;
  localparam int LVL_W   = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_LEAF_RD,
    OP_LEAF_WR,
    OP_UP_RD,
    OP_UP_WR,
    OP_ROOT_RD,
    OP_ROOT_CHK,
    OP_DN_RD,
    OP_DN_CHK,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

  // Reset maximum of a node: the first leaf it covers is p, so its maximum is -(p+1).
  function automatic val_t reset_max(input node_t idx);
    logic [KEY_W-1:0] lo;
    node_t strip;
    lo = '0;
    strip = '0;
    for (int l = 0; l < NODE_W; l++) begin
      if (idx[l]) begin
        strip = idx ^ (node_t'(1) << l);
        lo = KEY_W'(strip << (KEY_W - l));
      end
    end
    return -$signed({{(VAL_W-KEY_W){1'b0}}, lo}) - val_t'(1);
  endfunction

endpackage

// ===== src/sarnt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the tree block: clearing pass, bottom-up update and top-down search.
// Depends on sarnt_pkg for the command and status types.
module sarnt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sarnt_pkg::dp_status_t status,
  output sarnt_pkg::dp_cmd_t    cmd
);
  import sarnt_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEAF_RD, S_LEAF_WR, S_UP_RD, S_UP_WR,
    S_ROOT_RD, S_ROOT_CHK, S_DN_RD, S_DN_CHK, S_OUT
  } state_t;

  state_t state;
  logic [LVL_W-1:0] lvl;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_CLEAR:    cmd.op = OP_CLEAR;
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_LEAF_RD:  cmd.op = OP_LEAF_RD;
      S_LEAF_WR:  cmd.op = OP_LEAF_WR;
      S_UP_RD:    cmd.op = OP_UP_RD;
      S_UP_WR:    cmd.op = OP_UP_WR;
      S_ROOT_RD:  cmd.op = OP_ROOT_RD;
      S_ROOT_CHK: cmd.op = OP_ROOT_CHK;
      S_DN_RD:    cmd.op = OP_DN_RD;
      S_DN_CHK:   cmd.op = OP_DN_CHK;
      S_OUT:      cmd.op = status.out_free ? OP_OUT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      lvl   <= '0;
    end else begin
      unique case (state)
        S_CLEAR:   if (status.clear_last) state <= S_IDLE;
        S_IDLE:    if (in_valid) state <= S_LEAF_RD;
        S_LEAF_RD: state <= S_LEAF_WR;
        S_LEAF_WR: begin
          lvl   <= '0;
          state <= S_UP_RD;
        end
        S_UP_RD:   state <= S_UP_WR;
        S_UP_WR: begin
          lvl <= lvl + LVL_W'(1);
          state <= (lvl == LVL_W'(LEVELS - 1)) ? S_ROOT_RD : S_UP_RD;
        end
        S_ROOT_RD: state <= S_ROOT_CHK;
        S_ROOT_CHK: begin
          lvl   <= '0;
          state <= S_DN_RD;
        end
        S_DN_RD:   state <= S_DN_CHK;
        S_DN_CHK: begin
          lvl <= lvl + LVL_W'(1);
          state <= (lvl == LVL_W'(LEVELS - 1)) ? S_OUT : S_DN_RD;
        end
        S_OUT:     if (status.out_free) state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sarnt_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the tree block: per-node add and maximum memories, path registers
// and the output register. Depends on sarnt_pkg.
module sarnt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  sarnt_pkg::dp_cmd_t          cmd,
  output sarnt_pkg::dp_status_t       status,
  input  logic                        in_command,
  input  logic [sarnt_pkg::KEY_W-1:0] in_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sarnt_pkg::ANS_W-1:0] out_answer
);
  import sarnt_pkg::*;

  // add_mem: add applied to the whole subtree; mx_mem: subtree maximum without it.
  val_t add_mem [2**NODE_W];
  val_t mx_mem  [2**NODE_W];

  node_t rd_a_addr, rd_b_addr, wr_add_addr, wr_mx_addr, clr_cnt, node;
  val_t  add_a, mx_a, add_b, wr_add_data, wr_mx_data;
  logic  wr_add_en, wr_mx_en, found;
  val_t  d, vchild, acc;
  val_t  new_add, vsib, m, vr;

  always_comb begin
    rd_a_addr = node;
    rd_b_addr = node >> 1;
    unique case (cmd.op)
      OP_UP_RD: begin
        rd_a_addr = node ^ node_t'(1);
        rd_b_addr = node >> 1;
      end
      OP_ROOT_RD: rd_a_addr = node_t'(1);
      OP_DN_RD: begin
        rd_a_addr = {node[NODE_W-2:0], 1'b1};
        rd_b_addr = {node[NODE_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  always_comb begin
    new_add = add_a + d;
    vsib    = mx_a + ((node[0] == 1'b0) ? new_add : add_a);
    m       = (vchild > vsib) ? vchild : vsib;
    vr      = acc + add_a + mx_a;
    wr_add_en   = 1'b0;
    wr_mx_en    = 1'b0;
    wr_add_addr = node;
    wr_mx_addr  = node >> 1;
    wr_add_data = new_add;
    wr_mx_data  = m;
    unique case (cmd.op)
      OP_CLEAR: begin
        wr_add_en   = 1'b1;
        wr_mx_en    = 1'b1;
        wr_add_addr = clr_cnt;
        wr_mx_addr  = clr_cnt;
        wr_add_data = '0;
        wr_mx_data  = reset_max(clr_cnt);
      end
      OP_LEAF_WR: wr_add_en = 1'b1;
      OP_UP_WR: begin
        wr_add_en   = (node[0] == 1'b0);
        wr_add_addr = node ^ node_t'(1);
        wr_mx_en    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    add_a <= add_mem[rd_a_addr];
    mx_a  <= mx_mem[rd_a_addr];
    add_b <= add_mem[rd_b_addr];
    if (wr_add_en) add_mem[wr_add_addr] <= wr_add_data;
    if (wr_mx_en)  mx_mem[wr_mx_addr]   <= wr_mx_data;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        node <= {1'b1, in_key};
        d    <= in_command ? -val_t'(1) : val_t'(1);
      end
      OP_LEAF_WR: vchild <= mx_a + new_add;
      OP_UP_WR: begin
        vchild <= m + add_b;
        node   <= node >> 1;
      end
      OP_ROOT_CHK: begin
        acc   <= add_a;
        found <= (mx_a + add_a) >= 0;
        node  <= node_t'(1);
      end
      OP_DN_CHK: begin
        if (vr >= 0) begin
          node <= {node[NODE_W-2:0], 1'b1};
          acc  <= acc + add_a;
        end else begin
          node <= {node[NODE_W-2:0], 1'b0};
          acc  <= acc + add_b;
        end
      end
      OP_OUT: out_answer <= found ? ANS_W'({1'b0, node[KEY_W-1:0]}) + ANS_W'(1) : '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + node_t'(1);
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign status.clear_last = &clr_cnt;
  assign status.out_free   = !out_valid || out_ready;

endmodule

// ===== src/suffix_add_rightmost_nonneg_tree_top.sv =====
`timescale 1ns / 1ps
// Each input word carries an insert or remove command (tuser) and a key (tdata); the block
// adds +1 or -1 to every counter from the key to the last of 1024 counters, where counter p
// starts at -(p+1), and returns the index plus one of the rightmost counter that is at
// least zero, or 0 if none is. After reset a clearing pass initializes the node memories
// before the first word is taken. Each word then passes through a leaf read and write, a
// bottom-up update with a read and a write state per tree level, a root read and check,
// a top-down search with a read and a check state per tree level, and the output step;
// each level is split into a read state and a later state because the node memories are
// read through a register. One word is handled at a time, and the next is taken only after
// the output step. A finished answer waits in the output register while the next word is
// processed, and holds that word up only at its output step.
module suffix_add_rightmost_nonneg_tree_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key [9:0], zeros above
  input  logic        s_axis_tuser,   // command [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // answer [10:0], zeros above
);
  import sarnt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [ANS_W-1:0] answer;

  sarnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sarnt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_command (s_axis_tuser),
    .in_key     (s_axis_tdata[KEY_W-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_answer (answer)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-ANS_W){1'b0}}, answer};

endmodule

// ===== verif/tb_suffix_add_rightmost_nonneg_tree_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for suffix_add_rightmost_nonneg_tree_top with random idles on both sides.
// It predicts each answer from a flat array of counters and depends on sarnt_pkg and the top level.
module tb_suffix_add_rightmost_nonneg_tree_top;
  import sarnt_pkg::*;

  localparam int NUM_LEAVES = 1 << KEY_W;
  localparam int RANDOM_WORDS = 1750;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
  } update_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  update_t              pending_updates[$];
  logic [ANS_W-1:0]     expected_answers[$];
  longint               counters[NUM_LEAVES];
  int                   errors;
  int                   cycles;
  int                   send_gap;
  int                   recv_gap;
  bit                   busy_phase;

  suffix_add_rightmost_nonneg_tree_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(input bit no_idle);
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // Saturation cannot be reached within this run, so a flat array is exact.
  function automatic logic [ANS_W-1:0] apply_update(input update_t u);
    logic [ANS_W-1:0] answer;
    answer = '0;
    for (int p = int'(u.key); p < NUM_LEAVES; p++)
      counters[p] += (u.command == CMD_INSERT) ? 1 : -1;
    for (int p = 0; p < NUM_LEAVES; p++)
      if (counters[p] >= 0) answer = ANS_W'(p + 1);
    return answer;
  endfunction

  task automatic add_update(input logic command, input logic [KEY_W-1:0] key);
    update_t u;
    u.command = command;
    u.key     = key;
    pending_updates.insert(pending_updates.size(), u);
  endtask

  always @(posedge clk) begin
    update_t next;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid)
        expected_answers.insert(expected_answers.size(),
                                apply_update(update_t'({s_axis_tuser,
                                                        s_axis_tdata[KEY_W-1:0]})));
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_updates.size() > 0) begin
        next = pending_updates.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(16-KEY_W){1'b0}}, next.key};
        s_axis_tuser  <= next.command;
        send_gap      <= pick_gap(busy_phase);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [ANS_W-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0d", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_answers.pop_front();
          if (m_axis_tdata !== {{(16-ANS_W){1'b0}}, want}) begin
            $display("%0t: answer mismatch, expected %0d, actual %0d",
                     $time, want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap      <= pick_gap(busy_phase);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    update_t u;
    int lo;
    errors = 0;
    cycles = 0;
    busy_phase = 1'b0;
    rst = 1'b1;
    for (int p = 0; p < NUM_LEAVES; p++) counters[p] = -(p + 1);

    add_update(CMD_INSERT, 10'd0);
    add_update(CMD_INSERT, 10'd1023);
    add_update(CMD_REMOVE, 10'd1023);
    add_update(CMD_REMOVE, 10'd0);
    add_update(CMD_REMOVE, 10'd0);
    add_update(CMD_INSERT, 10'd0);
    add_update(CMD_INSERT, 10'd0);
    add_update(CMD_INSERT, 10'h2AA);
    add_update(CMD_INSERT, 10'h155);
    add_update(CMD_INSERT, 10'd0);
    add_update(CMD_INSERT, 10'd1);
    add_update(CMD_REMOVE, 10'h3FF);
    add_update(CMD_REMOVE, 10'd512);
    add_update(CMD_INSERT, 10'd511);
    add_update(CMD_REMOVE, 10'd0);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1023);
      u.key = KEY_W'($urandom_range(lo, 1023));
      if ($urandom_range(0, 3) == 0) u.key = KEY_W'($urandom_range(0, 15));
      u.command = ($urandom_range(0, 9) < 6) ? CMD_INSERT : CMD_REMOVE;
      pending_updates.insert(pending_updates.size(), u);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_updates.size() > 0) begin
      @(posedge clk);
      if ($urandom_range(0, 299) == 0) busy_phase = !busy_phase;
    end
    do @(negedge clk); while (s_axis_tvalid || expected_answers.size() > 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
